### sv/xfd_pkg.sv
// Shared types and constants of the XOR-checked frame deframer.
`timescale 1ns / 1ps
`default_nettype none
package xfd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned RoleW  = 3;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_HEADER_FIRST  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_SECOND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [ByteW-1:0] HEADER_FIRST_RST  = 8'd170;
  localparam logic [ByteW-1:0] HEADER_SECOND_RST = 8'd85;
  localparam logic [ByteW-1:0] MAX_PAYLOAD_RST   = 8'd250;

  // Role of a byte within a frame
  typedef enum logic [RoleW-1:0] {
    ROLE_HUNT    = 3'd0,
    ROLE_HEADER  = 3'd1,
    ROLE_TYPE    = 3'd2,
    ROLE_LEN     = 3'd3,
    ROLE_PAYLOAD = 3'd4,
    ROLE_CHECK   = 3'd5
  } role_t;

  // Current configuration seen by the engine
  typedef struct packed {
    logic [ByteW-1:0] header_first;
    logic [ByteW-1:0] header_second;
    logic [ByteW-1:0] max_payload_length;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [ByteW-1:0] byte_value;
    role_t            byte_role;
    logic             frame_done;
    logic             frame_ok;
  } result_t;

endpackage
`default_nettype wire

### sv/xfd_if.sv
// Valid/ready channel interfaces for received bytes and result items.
`timescale 1ns / 1ps
`default_nettype none
interface xfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic [2:0] byte_role;
  logic       frame_done;
  logic       frame_ok;

  modport source (output valid, output byte_value, output byte_role,
                  output frame_done, output frame_ok, input ready);
  modport sink   (input valid, input byte_value, input byte_role,
                  input frame_done, input frame_ok, output ready);
endinterface
`default_nettype wire

### sv/xfd_cfg_regs.sv
// Configuration registers of the deframer, written through a plain write port.
`timescale 1ns / 1ps
`default_nettype none
module xfd_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [xfd_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [xfd_pkg::ByteW-1:0]   cfg_wdata,
  output xfd_pkg::cfg_t                    cfg
);
  import xfd_pkg::*;

  cfg_t cfg_r;

  // Update the addressed register; ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first       <= HEADER_FIRST_RST;
      cfg_r.header_second      <= HEADER_SECOND_RST;
      cfg_r.max_payload_length <= MAX_PAYLOAD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HEADER_FIRST:  cfg_r.header_first       <= cfg_wdata;
        CFG_HEADER_SECOND: cfg_r.header_second      <= cfg_wdata;
        CFG_MAX_PAYLOAD:   cfg_r.max_payload_length <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### sv/xfd_engine.sv
// Frame state machine with running XOR and the registered result stage.
`timescale 1ns / 1ps
`default_nettype none
module xfd_engine (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire xfd_pkg::cfg_t             cfg,
  input  wire logic                      step,
  input  wire logic [xfd_pkg::ByteW-1:0] byte_in,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output xfd_pkg::result_t               result,
  output logic                           can_take
);
  import xfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_TYPE    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic             saw_hf_r, saw_hf_nxt;
  logic [ByteW-1:0] bytes_left_r, bytes_left_nxt;
  logic [ByteW-1:0] xor_r, xor_nxt;
  logic             out_valid_r;
  result_t          result_r, result_nxt;

  // Result register is free when empty or being drained
  assign can_take = !out_valid_r || out_ready;

  // Next state and result for the byte at the input register
  always_comb begin
    phase_nxt              = phase_r;
    saw_hf_nxt             = saw_hf_r;
    bytes_left_nxt         = bytes_left_r;
    xor_nxt                = xor_r ^ byte_in;
    result_nxt.byte_value  = byte_in;
    result_nxt.byte_role   = ROLE_HUNT;
    result_nxt.frame_done  = 1'b0;
    result_nxt.frame_ok    = 1'b0;
    case (phase_r)
      PH_TYPE: begin
        result_nxt.byte_role = ROLE_TYPE;
        phase_nxt            = PH_LEN;
      end
      PH_LEN: begin
        result_nxt.byte_role = ROLE_LEN;
        if (byte_in == '0) begin
          phase_nxt = PH_CHECK;
        end else if (byte_in > cfg.max_payload_length) begin
          // Abandon the frame on an oversized length
          result_nxt.frame_done = 1'b1;
          phase_nxt             = PH_HUNT;
          saw_hf_nxt            = 1'b0;
        end else begin
          bytes_left_nxt = byte_in;
          phase_nxt      = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        result_nxt.byte_role = ROLE_PAYLOAD;
        if (bytes_left_r <= 8'd1) begin
          bytes_left_nxt = '0;
          phase_nxt      = PH_CHECK;
        end else begin
          bytes_left_nxt = bytes_left_r - 8'd1;
        end
      end
      PH_CHECK: begin
        result_nxt.byte_role  = ROLE_CHECK;
        result_nxt.frame_done = 1'b1;
        result_nxt.frame_ok   = (xor_nxt == '0);
        phase_nxt             = PH_HUNT;
        saw_hf_nxt            = 1'b0;
      end
      default: begin
        // Hunt for the header pair; second-byte match wins over a new start
        if (saw_hf_r && (byte_in == cfg.header_second)) begin
          result_nxt.byte_role = ROLE_HEADER;
          xor_nxt              = cfg.header_first ^ cfg.header_second;
          saw_hf_nxt           = 1'b0;
          phase_nxt            = PH_TYPE;
        end else begin
          xor_nxt    = xor_r;
          saw_hf_nxt = (byte_in == cfg.header_first);
          phase_nxt  = PH_HUNT;
        end
      end
    endcase
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      saw_hf_r     <= 1'b0;
      bytes_left_r <= '0;
      xor_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (step) begin
        phase_r      <= phase_nxt;
        saw_hf_r     <= saw_hf_nxt;
        bytes_left_r <= bytes_left_nxt;
        xor_r        <= xor_nxt;
        result_r     <= result_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule
`default_nettype wire

### sv/xor_checked_frame_deframer_top.sv
// Top level of the XOR-checked frame deframer: input register, config, engine.
//
//  channel  | direction | payload                                        | handshake
//  ---------+-----------+------------------------------------------------+-------------
//  in_ch    | in        | rx_byte[7:0]                                   | valid/ready
//  out_ch   | out       | byte_value[7:0] byte_role[2:0] frame_done/ok   | valid/ready
//  cfg_*    | in        | cfg_index[1:0] cfg_wdata[7:0]                  | cfg_wr_en
//
// One item per cycle sustained while out_ch is not stalled; an accepted item passes the input
// register, then the result register behind the state machine.
// Synchronous active-low reset clears the state machine, the valid flags and the
// configuration to its defaults. A stalled result register still lets the input
// register fill, so one further item is taken while the result waits.
`timescale 1ns / 1ps
`default_nettype none
module xor_checked_frame_deframer_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  xfd_in_if.sink                           in_ch,
  xfd_out_if.source                        out_ch,
  input  wire logic                        cfg_wr_en,
  input  wire logic [xfd_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [xfd_pkg::ByteW-1:0]   cfg_wdata
);
  import xfd_pkg::*;

  cfg_t             cfg;
  result_t          result;
  logic             out_valid;
  logic             can_take;
  logic             step;
  logic             in_valid_r;
  logic [ByteW-1:0] in_byte_r;

  xfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Advance the held item into the engine when the result register is free
  assign step        = in_valid_r && can_take;
  assign in_ch.ready = !in_valid_r || step;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
      if (in_ch.valid) begin
        in_byte_r <= in_ch.rx_byte;
      end
    end
  end

  xfd_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (step),
    .byte_in   (in_byte_r),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .result    (result),
    .can_take  (can_take)
  );

  // Drive the result channel
  assign out_ch.valid      = out_valid;
  assign out_ch.byte_value = result.byte_value;
  assign out_ch.byte_role  = result.byte_role;
  assign out_ch.frame_done = result.frame_done;
  assign out_ch.frame_ok   = result.frame_ok;

endmodule
`default_nettype wire

### sv/xfd_checker.sv
// Port-level checks of the deframer and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module xfd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] byte_value,
  input wire logic [2:0] byte_role,
  input wire logic       frame_done,
  input wire logic       frame_ok
);
  import xfd_pkg::*;

  // Result stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(byte_value) && $stable(byte_role)
      && $stable(frame_done) && $stable(frame_ok))
    else $error("result changed while stalled");

  // A good verdict comes only on a finished frame's checksum byte
  a_ok_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_ok |-> frame_done && (byte_role == ROLE_CHECK))
    else $error("frame_ok outside a checksum byte");

  // A frame ends only on a length or a checksum byte
  a_done_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_done |-> (byte_role == ROLE_LEN) || (byte_role == ROLE_CHECK))
    else $error("frame_done on a wrong role");

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind xor_checked_frame_deframer_top xfd_checker u_xfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .byte_value (out_ch.byte_value),
  .byte_role  (out_ch.byte_role),
  .frame_done (out_ch.frame_done),
  .frame_ok   (out_ch.frame_ok)
);
`default_nettype wire

### tb/tb_xor_checked_frame_deframer_top.sv
// Self-checking bench for the XOR-checked frame deframer with its own frame predictor.
`timescale 1ns / 1ps
module tb_xor_checked_frame_deframer_top;
  import xfd_pkg::*;

  // Frame position tracked by the predictor
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_TYPE    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } frame_phase_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CfgIdxW-1:0] cfg_index;
  logic [ByteW-1:0] cfg_wdata;

  xfd_in_if in_if ();
  xfd_out_if out_if ();

  xor_checked_frame_deframer_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Stimulus bytes waiting for the driver and results waiting for the DUT
  logic [7:0] rx_stream[$];
  result_t predicted_bytes[$];
  int unsigned bytes_queued;
  int unsigned results_seen;
  int unsigned mismatches;

  // Predictor state and its copy of the configuration
  cfg_t live_cfg;
  frame_phase_t fr_phase;
  logic header_seen;
  logic [7:0] payload_left;
  logic [7:0] xor_acc;

  // Handshake and idling control
  logic in_fire;
  logic idle_on;
  int unsigned send_gap;
  int unsigned recv_stall;

  // Advance the frame predictor by one received byte
  function automatic result_t deframe_byte(logic [7:0] b);
    result_t r;
    r.byte_value = b;
    r.byte_role  = ROLE_HUNT;
    r.frame_done = 1'b0;
    r.frame_ok   = 1'b0;
    case (fr_phase)
      PH_TYPE: begin
        r.byte_role = ROLE_TYPE;
        xor_acc = xor_acc ^ b;
        fr_phase = PH_LEN;
      end
      PH_LEN: begin
        r.byte_role = ROLE_LEN;
        xor_acc = xor_acc ^ b;
        if (b == 8'd0) begin
          fr_phase = PH_CHECK;
        end else if (b > live_cfg.max_payload_length) begin
          // abandon an oversized frame
          r.frame_done = 1'b1;
          fr_phase = PH_HUNT;
          header_seen = 1'b0;
        end else begin
          payload_left = b;
          fr_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r.byte_role = ROLE_PAYLOAD;
        xor_acc = xor_acc ^ b;
        if (payload_left <= 8'd1) begin
          payload_left = 8'd0;
          fr_phase = PH_CHECK;
        end else begin
          payload_left = payload_left - 8'd1;
        end
      end
      PH_CHECK: begin
        r.byte_role = ROLE_CHECK;
        xor_acc = xor_acc ^ b;
        r.frame_done = 1'b1;
        r.frame_ok = (xor_acc == 8'd0);
        fr_phase = PH_HUNT;
        header_seen = 1'b0;
      end
      default: begin
        // second header byte is tested before a new header start
        if (header_seen && b == live_cfg.header_second) begin
          r.byte_role = ROLE_HEADER;
          xor_acc = live_cfg.header_first ^ live_cfg.header_second;
          header_seen = 1'b0;
          fr_phase = PH_TYPE;
        end else begin
          header_seen = (b == live_cfg.header_first);
          fr_phase = PH_HUNT;
        end
      end
    endcase
    return r;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  // Drive the input channel at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (send_gap > 0) begin
        in_if.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        in_if.valid <= 1'b0;
        send_gap <= $urandom_range(0, 16);
      end else if (rx_stream.size() > 0) begin
        in_if.rx_byte <= rx_stream.pop_front();
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Stall the result channel in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (recv_stall > 0) begin
      out_if.ready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_if.ready <= 1'b0;
      recv_stall <= $urandom_range(0, 16);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Predict on every accepted byte, check every accepted result
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        predicted_bytes.push_back(deframe_byte(in_if.rx_byte));
      end
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        got.byte_value = out_if.byte_value;
        got.byte_role  = role_t'(out_if.byte_role);
        got.frame_done = out_if.frame_done;
        got.frame_ok   = out_if.frame_ok;
        if (predicted_bytes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual %h", $time, got);
        end else begin
          want = predicted_bytes.pop_front();
          if (got.byte_value !== want.byte_value) begin
            mismatches++;
            $display("%0t: byte_value: expected %h, actual %h", $time,
                     want.byte_value, got.byte_value);
          end
          if (got.byte_role !== want.byte_role) begin
            mismatches++;
            $display("%0t: byte_role: expected %0d, actual %0d", $time,
                     want.byte_role, got.byte_role);
          end
          if (got.frame_done !== want.frame_done) begin
            mismatches++;
            $display("%0t: frame_done: expected %b, actual %b", $time,
                     want.frame_done, got.frame_done);
          end
          if (got.frame_ok !== want.frame_ok) begin
            mismatches++;
            $display("%0t: frame_ok: expected %b, actual %b", $time,
                     want.frame_ok, got.frame_ok);
          end
        end
      end
    end
  end

  task automatic add_byte(logic [7:0] b);
    rx_stream.push_back(b);
    bytes_queued++;
  endtask

  // Write one register while the block is idle
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_HEADER_FIRST:  live_cfg.header_first = val;
      CFG_HEADER_SECOND: live_cfg.header_second = val;
      default:           live_cfg.max_payload_length = val;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] h1, logic [7:0] h2, logic [7:0] max_len);
    write_reg(CFG_HEADER_FIRST, h1);
    write_reg(CFG_HEADER_SECOND, h2);
    write_reg(CFG_MAX_PAYLOAD, max_len);
  endtask

  // Queue one frame; an oversized length ends it after the length byte
  task automatic push_frame(logic [7:0] ftype, logic [7:0] flen, bit good);
    logic [7:0] acc;
    logic [7:0] p;
    acc = live_cfg.header_first ^ live_cfg.header_second ^ ftype ^ flen;
    add_byte(live_cfg.header_first);
    add_byte(live_cfg.header_second);
    add_byte(ftype);
    add_byte(flen);
    if (flen > live_cfg.max_payload_length) return;
    for (int i = 0; i < flen; i++) begin
      p = 8'($urandom_range(0, 255));
      acc = acc ^ p;
      add_byte(p);
    end
    add_byte(good ? acc : acc ^ 8'($urandom_range(1, 255)));
  endtask

  // Mostly well-formed frames, plus bad checksums, oversize, truncation and noise
  task automatic run_traffic(int unsigned n);
    int unsigned start;
    int unsigned kind;
    int unsigned cap;
    int unsigned lmax;
    logic [7:0] flen;
    start = bytes_queued;
    lmax = live_cfg.max_payload_length;
    cap = (lmax < 12) ? lmax : 12;
    while (bytes_queued - start < n) begin
      kind = $urandom_range(0, 99);
      flen = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, lmax))
                                          : 8'($urandom_range(0, cap));
      if ($urandom_range(0, 4) == 0) add_byte(live_cfg.header_first);
      if (kind < 60) begin
        push_frame(8'($urandom_range(0, 255)), flen, 1'b1);
      end else if (kind < 72) begin
        push_frame(8'($urandom_range(0, 255)), flen, 1'b0);
      end else if (kind < 80 && lmax < 255) begin
        push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(lmax + 1, 255)), 1'b0);
      end else if (kind < 90) begin
        add_byte(live_cfg.header_first);
        add_byte(live_cfg.header_second);
        repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          add_byte(($urandom_range(0, 3) == 0) ? live_cfg.header_first
                                               : 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // Wait until every byte is sent and every result has come back
  task automatic drain();
    while (rx_stream.size() != 0 || results_seen != bytes_queued) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // Reset, then directed frames and random traffic under several settings
  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_HEADER_FIRST;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.rx_byte = '0;
    out_if.ready = 1'b0;
    in_fire = 1'b0;
    idle_on = 1'b1;
    send_gap = 0;
    recv_stall = 0;
    bytes_queued = 0;
    results_seen = 0;
    mismatches = 0;
    live_cfg.header_first = HEADER_FIRST_RST;
    live_cfg.header_second = HEADER_SECOND_RST;
    live_cfg.max_payload_length = MAX_PAYLOAD_RST;
    fr_phase = PH_HUNT;
    header_seen = 1'b0;
    payload_left = '0;
    xor_acc = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset configuration: extreme bytes, repeated header start, zero length,
    // oversized length, bad checksum, broken header
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(live_cfg.header_first);
    push_frame(8'hFF, 8'd0, 1'b1);
    push_frame(8'h00, 8'd251, 1'b0);
    push_frame(8'h01, 8'd2, 1'b0);
    add_byte(live_cfg.header_first);
    add_byte(8'h00);
    add_byte(live_cfg.header_second);
    run_traffic(200);
    drain();

    // Smallest limit: zero length kept, length one accepted, length two abandoned
    set_config(8'h00, 8'hFF, 8'd1);
    push_frame(8'h5A, 8'd0, 1'b1);
    push_frame(8'hA5, 8'd1, 1'b1);
    push_frame(8'h0F, 8'd2, 1'b0);
    run_traffic(200);
    drain();

    // Largest limit with one full-length frame
    set_config(8'hFF, 8'h00, 8'd255);
    push_frame(8'h33, 8'd255, 1'b1);
    run_traffic(200);
    drain();

    // Equal header bytes
    set_config(8'h3C, 8'h3C, 8'($urandom_range(1, 255)));
    run_traffic(200);
    drain();

    // Random headers, no idling in the tail
    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(1, 40)));
    idle_on = 1'b0;
    run_traffic(200);
    drain();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
